// ===== hw/rtl/sti_pkg.sv =====
// Shared types and constants for the sorted key table.
// Used by the stream interface and by the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sti_pkg;

  // Fixed widths of the item fields.
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned POS_BITS = 9;

  // Operation codes carried in the kind field.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // Input item: one operation on one key.
  typedef struct packed {
    logic                kind;
    logic [KEY_BITS-1:0] key;
  } req_t;

  // Result item: one per input item.
  typedef struct packed {
    logic [POS_BITS-1:0] position;
    logic                found;
    logic                full_res;
  } rsp_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE_RD,
    ST_PROBE_CMP,
    ST_SHIFT,
    ST_WRITE,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/sti_stream_if.sv =====
// Valid/ready stream channel that carries one payload item per handshake.
// The payload type comes from sti_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sti_stream_if #(
  parameter type T = sti_pkg::req_t
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sorted_table_insert_search.sv =====
// Sorted key table with binary-search insert and lookup, top level.
// Depends on sti_pkg and sti_stream_if.
//
// The block holds up to DEPTH keys in ascending unsigned order. Each item is
// an insert or a lookup and yields one result item. One item is worked on at
// a time: each binary-search probe is a registered memory read, then a
// compare, with at most log2(DEPTH)+1 probes, and an insert then moves every
// entry above its slot up by one at one entry per cycle through the single
// memory port pair, then writes the key. At the default depth the shortest
// item is a lookup in an empty table and the longest an insert at the front
// of a table that holds 255 keys. An insert into a full table leaves the
// table alone and reports full_res. Key bits above KEY_WIDTH are ignored.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_insert_search #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sti_stream_if.sink   req_i,
  sti_stream_if.source rsp_o
);

  // Stored key width, count width and memory address width.
  localparam int unsigned KW = (KEY_WIDTH < sti_pkg::KEY_BITS) ? KEY_WIDTH
                                                                 : sti_pkg::KEY_BITS;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);

  // Key memory.
  logic [KW-1:0] mem_q [DEPTH];
  logic [KW-1:0] rdata_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [KW-1:0] wr_data;

  // Control state.
  sti_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   lo_q, lo_d;
  logic [CW-1:0]   hx_q, hx_d;
  logic [CW-1:0]   mid_q, mid_d;
  logic [CW-1:0]   j_q, j_d;
  logic            pend_q, pend_d;
  logic [AW-1:0]   wa_q, wa_d;
  logic            out_valid_q, out_valid_d;

  // Item data.
  logic [KW-1:0]   key_q, key_d;
  logic            kind_q, kind_d;
  logic [CW-1:0]   pos_q, pos_d;
  logic            found_q, found_d;
  logic            full_q, full_d;
  sti_pkg::rsp_t   out_q, out_d;

  // Probe midpoint and shift helpers.
  logic [CW:0]     mid_sum;
  logic [CW-1:0]   mid_c;
  logic [CW-1:0]   j_m1;
  logic [CW-1:0]   mid_p1;
  logic            tbl_full;

  assign mid_sum  = {1'b0, lo_q} + {1'b0, hx_q} - {{CW{1'b0}}, 1'b1};
  assign mid_c    = mid_sum[CW:1];
  assign j_m1     = j_q - {{(CW-1){1'b0}}, 1'b1};
  assign mid_p1   = mid_q + {{(CW-1){1'b0}}, 1'b1};
  assign tbl_full = (count_q == CW'(DEPTH));

  assign req_i.ready = (state_q == sti_pkg::ST_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // Sequencer: search, then shift and write on an insert.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hx_d        = hx_q;
    mid_d       = mid_q;
    j_d         = j_q;
    pend_d      = 1'b0;
    wa_d        = wa_q;
    out_valid_d = out_valid_q;
    key_d       = key_q;
    kind_d      = kind_q;
    pos_d       = pos_q;
    found_d     = found_q;
    full_d      = full_q;
    out_d       = out_q;
    rd_addr     = mid_c[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = wa_q;
    wr_data     = rdata_q;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      sti_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          key_d   = KW'(req_i.data.key);
          kind_d  = req_i.data.kind;
          lo_d    = '0;
          hx_d    = count_q;
          found_d = 1'b0;
          full_d  = 1'b0;
          state_d = sti_pkg::ST_PROBE_RD;
        end
      end

      sti_pkg::ST_PROBE_RD: begin
        if (lo_q < hx_q) begin
          // Issue the read of the midpoint entry.
          mid_d   = mid_c;
          state_d = sti_pkg::ST_PROBE_CMP;
        end else begin
          // Search ended without a match: the insertion point is lo.
          pos_d = lo_q;
          j_d   = count_q;
          if (kind_q == sti_pkg::KIND_LOOKUP) begin
            state_d = sti_pkg::ST_DONE;
          end else if (tbl_full) begin
            full_d  = 1'b1;
            state_d = sti_pkg::ST_DONE;
          end else begin
            state_d = sti_pkg::ST_SHIFT;
          end
        end
      end

      sti_pkg::ST_PROBE_CMP: begin
        priority if (rdata_q > key_q) begin
          hx_d    = mid_q;
          state_d = sti_pkg::ST_PROBE_RD;
        end else if (rdata_q < key_q) begin
          lo_d    = mid_p1;
          state_d = sti_pkg::ST_PROBE_RD;
        end else begin
          // Equal key: a lookup reports it, an insert goes right after it.
          j_d = count_q;
          if (kind_q == sti_pkg::KIND_LOOKUP) begin
            pos_d   = mid_q;
            found_d = 1'b1;
            state_d = sti_pkg::ST_DONE;
          end else begin
            pos_d = mid_p1;
            if (tbl_full) begin
              full_d  = 1'b1;
              state_d = sti_pkg::ST_DONE;
            end else begin
              state_d = sti_pkg::ST_SHIFT;
            end
          end
        end
      end

      sti_pkg::ST_SHIFT: begin
        // Write the entry read last cycle one slot higher.
        wr_en   = pend_q;
        rd_addr = j_m1[AW-1:0];
        if (j_q > pos_q) begin
          pend_d = 1'b1;
          wa_d   = j_q[AW-1:0];
          j_d    = j_m1;
        end else begin
          state_d = sti_pkg::ST_WRITE;
        end
      end

      sti_pkg::ST_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = pos_q[AW-1:0];
        wr_data = key_q;
        count_d = count_q + {{(CW-1){1'b0}}, 1'b1};
        state_d = sti_pkg::ST_DONE;
      end

      sti_pkg::ST_DONE: begin
        // Load the output register once it is free.
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d    = 1'b1;
          out_d.position = sti_pkg::POS_BITS'(pos_q);
          out_d.found    = found_q;
          out_d.full_res = full_q;
          state_d        = sti_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = sti_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sti_pkg::ST_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hx_q    <= hx_d;
    mid_q   <= mid_d;
    j_q     <= j_d;
    wa_q    <= wa_d;
    key_q   <= key_d;
    kind_q  <= kind_d;
    pos_q   <= pos_d;
    found_q <= found_d;
    full_q  <= full_d;
    out_q   <= out_d;
  end

  // Memory write port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // Memory read port with registered data.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[rd_addr];
  end

  // The count never goes past the depth.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  // Every key write grows the table by exactly one entry.
  a_write_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sti_pkg::ST_WRITE |=> count_q == $past(count_q) + 1'b1)
    else $error("count did not advance after key write");

  // A refused insert is only reported while the table is full.
  a_full_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.full_res |-> tbl_full && !out_q.found)
    else $error("full flag without a full table");

  // Shifting never writes at or below the target slot.
  a_shift_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sti_pkg::ST_SHIFT && pend_q |-> CW'(wa_q) > pos_q)
    else $error("shift writes below the insert slot");

endmodule

`default_nettype wire
